@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the header parser.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold on every clock edge
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/hhsp_pkg.sv @@
// Shared types and codes of the HTTP header stream parser.
// No dependencies; imported by every module of the block.
package hhsp_pkg;

	// Counter and content-length widths
	localparam int COUNT_WIDTH  = 16;
	localparam int LENGTH_WIDTH = 32;

	typedef logic [COUNT_WIDTH-1:0]  cnt_t;
	typedef logic [LENGTH_WIDTH-1:0] len_t;

	// Field tags
	localparam logic [2:0] TAG_NONE    = 3'd0;
	localparam logic [2:0] TAG_METHOD  = 3'd1;
	localparam logic [2:0] TAG_URI     = 3'd2;
	localparam logic [2:0] TAG_VERSION = 3'd3;
	localparam logic [2:0] TAG_CODE    = 3'd4;
	localparam logic [2:0] TAG_REASON  = 3'd5;
	localparam logic [2:0] TAG_HNAME   = 3'd6;
	localparam logic [2:0] TAG_HVALUE  = 3'd7;

	// Parse status
	localparam logic [1:0] STAT_RUN        = 2'd0;
	localparam logic [1:0] STAT_DONE       = 2'd1;
	localparam logic [1:0] STAT_ERROR      = 2'd2;
	localparam logic [1:0] STAT_INCOMPLETE = 2'd3;

	// Method classification
	localparam logic [2:0] OP_UNKNOWN  = 3'd0;
	localparam logic [2:0] OP_GET      = 3'd1;
	localparam logic [2:0] OP_PUT      = 3'd2;
	localparam logic [2:0] OP_POST     = 3'd3;
	localparam logic [2:0] OP_RESPONSE = 3'd4;

	// Error location
	localparam logic [2:0] WHERE_NONE    = 3'd0;
	localparam logic [2:0] WHERE_METHOD  = 3'd1;
	localparam logic [2:0] WHERE_CODE    = 3'd2;
	localparam logic [2:0] WHERE_VERSION = 3'd3;
	localparam logic [2:0] WHERE_HNAME   = 3'd4;

	// One classified input word, front to back
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] lower;      // data folded to lower case
		logic [3:0] digit_val;
		logic       is_digit;
		logic       is_blank;   // space or tab
		logic       is_nl;
		logic       is_cr;
		logic       is_name;    // alphanumeric or dash
		logic       is_colon;
		logic       first;
		logic       last;
	} byte_info_t;

	// One result word
	typedef struct packed {
		logic [2:0]  field_tag;
		logic        field_start;
		logic [1:0]  parse_status;
		logic [2:0]  op_kind;
		logic [15:0] status_code;
		logic [7:0]  header_count;
		logic [31:0] content_length;
		logic [15:0] header_length;
		logic [2:0]  error_where;
		logic [15:0] error_line;
		logic [15:0] error_column;
	} result_t;

endpackage

@@ rtl/core/hhsp_front.sv @@
// Front end of the header parser: accepts input words and classifies bytes.
// Depends on hhsp_pkg; feeds hhsp_queue.
module hhsp_front (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic [0:0]           s_tuser,   // [0] first_byte
	input  logic                 s_tlast,   // last_byte
	output logic                 push_valid,
	input  logic                 push_ready,
	output hhsp_pkg::byte_info_t push_entry
);
	import hhsp_pkg::*;

	logic is_upper;
	logic is_lower;

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;

	// Character classes
	always_comb begin
		is_upper = (s_tdata >= "A") && (s_tdata <= "Z");
		is_lower = (s_tdata >= "a") && (s_tdata <= "z");
		push_entry.data      = s_tdata;
		push_entry.lower     = is_upper ? (s_tdata + 8'd32) : s_tdata;
		push_entry.digit_val = s_tdata[3:0];
		push_entry.is_digit  = (s_tdata >= "0") && (s_tdata <= "9");
		push_entry.is_blank  = (s_tdata == " ") || (s_tdata == 8'h09);
		push_entry.is_nl     = (s_tdata == 8'h0A);
		push_entry.is_cr     = (s_tdata == 8'h0D);
		push_entry.is_name   = push_entry.is_digit || is_upper || is_lower || (s_tdata == "-");
		push_entry.is_colon  = (s_tdata == ":");
		push_entry.first     = s_tuser[0];
		push_entry.last      = s_tlast;
	end

endmodule

@@ rtl/core/hhsp_queue.sv @@
// Two-entry queue of classified words between front and back end.
// Depends on hhsp_pkg.
module hhsp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hhsp_pkg::byte_info_t in_entry,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hhsp_pkg::byte_info_t out_entry
);
	import hhsp_pkg::*;

	localparam int DEPTH = 2;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	byte_info_t        mem_q [DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [CW-1:0]     cnt_q;
	logic              push;
	logic              pop;

	assign in_ready  = (cnt_q != CW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_entry = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/hhsp_back.sv @@
// Back end of the header parser: parse state machine and result register.
// Depends on hhsp_pkg and assert_macros.svh; fed by hhsp_queue.
`include "assert_macros.svh"
module hhsp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hhsp_pkg::byte_info_t in_entry,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hhsp_pkg::result_t    out_res
);
	import hhsp_pkg::*;

	typedef enum logic [3:0] {
		P_INIT    = 4'd0,
		P_SPACE   = 4'd1,
		P_OP      = 4'd2,
		P_CODE    = 4'd3,
		P_MSG     = 4'd4,
		P_URI     = 4'd5,
		P_VERSION = 4'd6,
		P_HBOL    = 4'd7,
		P_HEADER  = 4'd8,
		P_HNAME   = 4'd9,
		P_HVAL    = 4'd10,
		P_DONE    = 4'd11,
		P_ERROR   = 4'd12
	} pstate_t;

	localparam int   LW4       = LENGTH_WIDTH + 4;
	localparam int   LF_ACTIVE = 0;
	localparam int   LF_DIGIT  = 1;
	localparam int   LF_ENDED  = 2;
	localparam len_t LEN_MAX   = '1;

	// Keyword matchers: hit when position p holds byte b
	function automatic logic get_hit(logic [2:0] p, logic [7:0] b);
		case (p)
			3'd0:    return b == "G";
			3'd1:    return b == "E";
			3'd2:    return b == "T";
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic put_hit(logic [2:0] p, logic [7:0] b);
		case (p)
			3'd0:    return b == "P";
			3'd1:    return b == "U";
			3'd2:    return b == "T";
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic post_hit(logic [2:0] p, logic [7:0] b);
		case (p)
			3'd0:    return b == "P";
			3'd1:    return b == "O";
			3'd2:    return b == "S";
			3'd3:    return b == "T";
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic http_hit(logic [2:0] p, logic [7:0] b);
		case (p)
			3'd0:    return b == "H";
			3'd1:    return b == "T";
			3'd2:    return b == "T";
			3'd3:    return b == "P";
			3'd4:    return b == "/";
			default: return 1'b0;
		endcase
	endfunction

	// Method tracker: [2:0] position, [3] GET, [4] PUT, [5] POST, [6] HTTP/
	function automatic logic [7:0] method_step(logic [7:0] mm, logic [7:0] b);
		logic [2:0] p;
		logic [7:0] m;
		p    = mm[2:0];
		m    = '0;
		m[3] = mm[3] && get_hit(p, b);
		m[4] = mm[4] && put_hit(p, b);
		m[5] = mm[5] && post_hit(p, b);
		m[6] = mm[6] && ((p >= 3'd5) || http_hit(p, b));
		m[2:0] = (p < 3'd7) ? p + 3'd1 : 3'd7;
		return m;
	endfunction

	function automatic logic [2:0] method_kind(logic [7:0] mm);
		if (mm[6] && (mm[2:0] >= 3'd5)) return OP_RESPONSE;
		if (mm[3] && (mm[2:0] == 3'd3)) return OP_GET;
		if (mm[4] && (mm[2:0] == 3'd3)) return OP_PUT;
		if (mm[5] && (mm[2:0] == 3'd4)) return OP_POST;
		return OP_UNKNOWN;
	endfunction

	// "content-length" matcher, lower-cased input
	function automatic logic [7:0] clen_char(logic [3:0] i);
		case (i)
			4'd0:    return "c";
			4'd1:    return "o";
			4'd2:    return "n";
			4'd3:    return "t";
			4'd4:    return "e";
			4'd5:    return "n";
			4'd6:    return "t";
			4'd7:    return "-";
			4'd8:    return "l";
			4'd9:    return "e";
			4'd10:   return "n";
			4'd11:   return "g";
			4'd12:   return "t";
			4'd13:   return "h";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [3:0] name_step(logic [3:0] idx, logic [7:0] c);
		if ((idx < 4'd14) && (clen_char(idx) == c)) return idx + 4'd1;
		return 4'd15;
	endfunction

	function automatic cnt_t cnt_inc(cnt_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Parse state
	pstate_t      ps_q, sas_q;
	logic [7:0]   mm_q;
	cnt_t         lc_q, cc_q, bc_q;
	logic [15:0]  cv_q;
	logic [1:0]   cf_q;
	logic [3:0]   nmi_q;
	logic [2:0]   lf_q;
	len_t         lv_q;
	logic [7:0]   ht_q;
	logic [2:0]   op_q;
	logic [2:0]   ew_q;
	logic [15:0]  el_q, ecol_q;
	logic         out_valid_q;
	result_t      res_q;

	// Starting values (after an optional clear) and next values
	pstate_t      ps_c, sas_c, ps_n, sas_n, st;
	logic [7:0]   mm_c, mm_n;
	cnt_t         lc_c, cc_c, bc_c, lc_n, cc_n, bc_n, col;
	logic [15:0]  cv_c, cv_n, cv_st;
	logic [1:0]   cf_c, cf_n, cf_st;
	logic [3:0]   nmi_c, nmi_n;
	logic [2:0]   lf_c, lf_n, lf_st;
	len_t         lv_c, lv_n, lv_st;
	logic [7:0]   ht_c, ht_n;
	logic [2:0]   op_c, op_n, ew_c, ew_n;
	logic [15:0]  el_c, ecol_c, el_n, ecol_n;
	logic [19:0]  code_prod;
	logic [LW4-1:0] len_prod;
	logic         run, fresh, sp, nl;
	logic [2:0]   tag;
	result_t      res_n;
	logic         pop;

	assign in_ready  = !out_valid_q || out_ready;
	assign pop       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// Clear on first byte of a message
	always_comb begin
		if (in_entry.first) begin
			ps_c = P_INIT;  sas_c = P_INIT; mm_c = '0;
			lc_c = '0;      cc_c = '0;      bc_c = '0;
			cv_c = '0;      cf_c = '0;      nmi_c = '0;
			lf_c = '0;      lv_c = '0;      ht_c = '0;
			op_c = '0;      ew_c = '0;      el_c = '0;  ecol_c = '0;
		end else begin
			ps_c = ps_q;    sas_c = sas_q;  mm_c = mm_q;
			lc_c = lc_q;    cc_c = cc_q;    bc_c = bc_q;
			cv_c = cv_q;    cf_c = cf_q;    nmi_c = nmi_q;
			lf_c = lf_q;    lv_c = lv_q;    ht_c = ht_q;
			op_c = op_q;    ew_c = ew_q;    el_c = el_q; ecol_c = ecol_q;
		end
	end

	// Status code digit accumulation
	always_comb begin
		code_prod = 20'({cv_c, 3'b000}) + 20'({cv_c, 1'b0}) + 20'(in_entry.digit_val);
		cv_st = cv_c;
		cf_st = cf_c;
		if (!cf_c[0]) begin
			if (in_entry.is_digit) begin
				cv_st = (code_prod > 20'd65535) ? 16'hFFFF : code_prod[15:0];
				cf_st[1] = 1'b1;
			end else begin
				cf_st[0] = 1'b1;
			end
		end
	end

	// Content-length digit accumulation
	always_comb begin
		len_prod = LW4'({lv_c, 3'b000}) + LW4'({lv_c, 1'b0}) + LW4'(in_entry.digit_val);
		lv_st = lv_c;
		lf_st = lf_c;
		if (lf_c[LF_ACTIVE] && !lf_c[LF_ENDED]) begin
			if (in_entry.is_digit) begin
				lv_st = (len_prod > LW4'(LEN_MAX)) ? LEN_MAX : len_prod[LENGTH_WIDTH-1:0];
				lf_st[LF_DIGIT] = 1'b1;
			end else if (!lf_c[LF_DIGIT] && (in_entry.is_blank || in_entry.is_nl)) begin
				lf_st = lf_c;
			end else begin
				lf_st[LF_ENDED] = 1'b1;
			end
		end
	end

	// Parser step for one word
	always_comb begin
		ps_n = ps_c;   sas_n = sas_c;  mm_n = mm_c;
		lc_n = lc_c;   cc_n = cc_c;    bc_n = bc_c;
		cv_n = cv_c;   cf_n = cf_c;    nmi_n = nmi_c;
		lf_n = lf_c;   lv_n = lv_c;    ht_n = ht_c;
		op_n = op_c;   ew_n = ew_c;    el_n = el_c;  ecol_n = ecol_c;
		sp    = in_entry.is_blank;
		nl    = in_entry.is_nl;
		tag   = TAG_NONE;
		fresh = 1'b0;
		run   = 1'b1;
		st    = ps_c;
		col   = cc_c;
		if ((ps_c != P_DONE) && (ps_c != P_ERROR)) begin
			bc_n = cnt_inc(bc_c);
			if (nl) begin
				lc_n = cnt_inc(lc_c);
				col  = '0;
			end
			cc_n = cnt_inc(col);
			if (!in_entry.is_cr) begin
				// leave the blank run
				if (st == P_SPACE) begin
					if (sp) begin
						run = 1'b0;
					end else begin
						st    = sas_c;
						ps_n  = sas_c;
						fresh = 1'b1;
					end
				end
				// first word of the start line
				if (run && (st == P_INIT)) begin
					if (sp || nl) begin
						run = 1'b0;
					end else begin
						st    = P_OP;
						ps_n  = P_OP;
						mm_n  = 8'h78;
						fresh = 1'b1;
					end
				end
				if (run) begin
					unique case (st)
						P_OP: begin
							if (nl) begin
								ps_n = P_ERROR; ew_n = WHERE_METHOD;
								el_n = 16'(lc_n); ecol_n = 16'(col);
							end else if (sp) begin
								op_n  = method_kind(mm_n);
								ps_n  = P_SPACE;
								sas_n = (method_kind(mm_n) == OP_RESPONSE) ? P_CODE : P_URI;
							end else begin
								mm_n = method_step(mm_n, in_entry.data);
								tag  = TAG_METHOD;
							end
						end
						P_CODE: begin
							if (sp || nl) begin
								if (!cf_c[1]) begin
									ps_n = P_ERROR; ew_n = WHERE_CODE;
									el_n = 16'(lc_n); ecol_n = 16'(col);
								end else begin
									ps_n  = nl ? P_HEADER : P_SPACE;
									sas_n = P_MSG;
								end
							end else begin
								cv_n = cv_st;
								cf_n = cf_st;
								tag  = TAG_CODE;
							end
						end
						P_MSG: begin
							if (nl) ps_n = P_HEADER;
							else    tag  = TAG_REASON;
						end
						P_URI: begin
							if (sp || nl) begin
								ps_n  = P_SPACE;
								sas_n = nl ? P_HEADER : P_VERSION;
							end else begin
								tag = TAG_URI;
							end
						end
						P_VERSION: begin
							if (nl) begin
								ps_n = P_HEADER;
							end else if (sp) begin
								ps_n  = P_SPACE;
								sas_n = P_HBOL;
							end else begin
								tag = TAG_VERSION;
							end
						end
						P_HBOL: begin
							if (nl) begin
								ps_n = P_HEADER;
							end else begin
								ps_n = P_ERROR; ew_n = WHERE_VERSION;
								el_n = 16'(lc_n); ecol_n = 16'(col);
							end
						end
						P_HEADER: begin
							if (sp) begin
								// continuation line
								ps_n  = P_HVAL;
								lf_n  = lf_st;
								lv_n  = lv_st;
								fresh = 1'b0;
								tag   = TAG_HVALUE;
							end else if (nl) begin
								ps_n = P_DONE;
							end else begin
								if (ht_c != 8'hFF) ht_n = ht_c + 8'd1;
								if (lf_c[LF_ACTIVE]) lf_n[LF_ENDED] = 1'b1;
								nmi_n = name_step(4'd0, in_entry.lower);
								ps_n  = P_HNAME;
								fresh = 1'b1;
								tag   = TAG_HNAME;
							end
						end
						P_HNAME: begin
							if (in_entry.is_name) begin
								nmi_n = name_step(nmi_c, in_entry.lower);
								tag   = TAG_HNAME;
							end else if (in_entry.is_colon) begin
								if ((nmi_c == 4'd14) && !lf_c[LF_ACTIVE] && !lf_c[LF_ENDED]) begin
									lf_n = 3'b001;
									lv_n = '0;
								end
								ps_n  = P_SPACE;
								sas_n = P_HVAL;
							end else begin
								ps_n = P_ERROR; ew_n = WHERE_HNAME;
								el_n = 16'(lc_n); ecol_n = 16'(col);
							end
						end
						P_HVAL: begin
							lf_n = lf_st;
							lv_n = lv_st;
							if (nl) ps_n = P_HEADER;
							else    tag  = TAG_HVALUE;
						end
						default: begin
							tag = TAG_NONE;
						end
					endcase
				end
			end
		end
	end

	// Result word
	always_comb begin
		res_n.field_tag   = tag;
		res_n.field_start = fresh && (tag != TAG_NONE);
		if (ps_n == P_DONE)       res_n.parse_status = STAT_DONE;
		else if (ps_n == P_ERROR) res_n.parse_status = STAT_ERROR;
		else if (in_entry.last)   res_n.parse_status = STAT_INCOMPLETE;
		else                      res_n.parse_status = STAT_RUN;
		res_n.op_kind        = op_n;
		res_n.status_code    = cv_n;
		res_n.header_count   = ht_n;
		res_n.content_length = 32'(lv_n);
		res_n.header_length  = (ps_n == P_DONE) ? 16'(bc_n) : 16'h0000;
		res_n.error_where    = ew_n;
		res_n.error_line     = el_n;
		res_n.error_column   = ecol_n;
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q <= P_INIT;  sas_q <= P_INIT; mm_q <= '0;
			lc_q <= '0;      cc_q <= '0;      bc_q <= '0;
			cv_q <= '0;      cf_q <= '0;      nmi_q <= '0;
			lf_q <= '0;      lv_q <= '0;      ht_q <= '0;
			op_q <= '0;      ew_q <= '0;      el_q <= '0;  ecol_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				ps_q <= ps_n;    sas_q <= sas_n;  mm_q <= mm_n;
				lc_q <= lc_n;    cc_q <= cc_n;    bc_q <= bc_n;
				cv_q <= cv_n;    cf_q <= cf_n;    nmi_q <= nmi_n;
				lf_q <= lf_n;    lv_q <= lv_n;    ht_q <= ht_n;
				op_q <= op_n;    ew_q <= ew_n;    el_q <= el_n; ecol_q <= ecol_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

	`ASSERT_IMPL(a_error_has_where, ps_q == P_ERROR, ew_q != WHERE_NONE, "error without location")
	`ASSERT_IMPL(a_done_has_length, ps_q == P_DONE, bc_q != '0, "done with empty header")
	`ASSERT_NEXT(a_final_holds, (ps_q == P_DONE || ps_q == P_ERROR) && !(pop && in_entry.first), $stable(ps_q), "left final state without a new message")
	`ASSERT_NEXT(a_pop_loads_result, pop, out_valid_q, "taken word produced no result")

endmodule

@@ rtl/core/http_header_stream_parser.sv @@
// HTTP header stream parser, top level: byte stream in, tagged result stream out.
// Depends on hhsp_pkg, hhsp_front, hhsp_queue and hhsp_back.
//
// One header byte enters per word and yields exactly one result word. The block
// sustains one byte per clock cycle while m_tready is not held low; a result
// passes through the two-entry input queue and then the result register, and
// the parser state update handles one byte per cycle. A stalled output fills
// the queue and then drops s_tready; no reset sweep is needed, the block is
// ready right after reset. first_byte clears all parse state before its byte is
// taken. After done or error, bytes are still taken and answered, and every
// result field holds until the next first_byte.
module http_header_stream_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // last_byte
	input  logic [0:0]   s_tuser,   // [0] first_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [1:0] parse_status, [4:2] op_kind, [20:5] status_code, [28:21] header_count,
	// [60:29] content_length, [76:61] header_length, [79:77] error_where,
	// [95:80] error_line, [111:96] error_column
	output logic [111:0] m_tdata,
	output logic [3:0]   m_tuser    // [2:0] field_tag, [3] field_start
);
	import hhsp_pkg::*;

	byte_info_t push_entry;
	byte_info_t pop_entry;
	logic       push_valid, push_ready;
	logic       pop_valid, pop_ready;
	result_t    res;

	hhsp_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	hhsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_entry  (push_entry),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_entry (pop_entry)
	);

	hhsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pop_valid),
		.in_ready  (pop_ready),
		.in_entry  (pop_entry),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// Output packing
	assign m_tdata = {res.error_column, res.error_line, res.error_where, res.header_length,
			res.content_length, res.header_count, res.status_code, res.op_kind,
			res.parse_status};
	assign m_tuser = {res.field_start, res.field_tag};

endmodule
